>>> rtl/stru_pkg.sv
// ----------------------------------------------------------------------------
// stru_pkg
// Shared types, sizes and the name cleanup function for the trace ring.
// ----------------------------------------------------------------------------
package stru_pkg;

    localparam int SEQ_W      = 32;
    localparam int NAME_W     = 64;
    localparam int CNT_W      = 7;
    localparam int RING_DEPTH = 256;
    localparam int NAME_CHARS = 8;
    localparam int MAX_BURST  = 64;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int AV_W   = $clog2(RING_DEPTH + 1);

    localparam logic [SEQ_W-1:0] DEPTH_SEQ   = SEQ_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] MAX_BURST_C = CNT_W'(MAX_BURST);

    localparam logic [7:0] CH_US   = 8'h5F;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_EMPTY  = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_RESET = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SIZE,
        ST_SLOT,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SEQ_W-1:0]  time_ms;
        logic [31:0]       value_bits;
        logic [NAME_W-1:0] name_chars;
        logic [SEQ_W-1:0]  since_seq;
        logic [CNT_W-1:0]  max_count;
    } in_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  sample_time;
        logic [31:0]       sample_value;
        logic [NAME_W-1:0] sample_name;
        logic [SEQ_W-1:0]  next_seq;
        logic              last;
    } out_t;

    // one ring entry as stored in memory
    typedef struct packed {
        logic [SEQ_W-1:0]  time_ms;
        logic [31:0]       value_bits;
        logic [NAME_W-1:0] name;
    } ent_t;

    function automatic logic char_ok(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                          CH_US, CH_DOT, CH_DASH});
    endfunction

    // cut at first NUL, replace anything outside the allowed set by '_'
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              stop;
        logic [7:0]        c;
        res  = '0;
        stop = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            c = raw[8*i +: 8];
            if (c == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                res[8*i +: 8] = char_ok(c) ? c : CH_US;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/stru_ram.sv
// ----------------------------------------------------------------------------
// stru_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module stru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read data holds until the next read enable
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sequenced_trace_ring_unit.sv
// ----------------------------------------------------------------------------
// sequenced_trace_ring_unit
// Trace ring of timestamped samples addressed by a 32-bit write sequence.
// ----------------------------------------------------------------------------
// A put beat stores time, raw value bits and a cleaned-up name in the slot of
// the current write sequence: s_ready stays high, so puts stream at one per
// clock, each a single memory write. A read beat clamps its start to the
// oldest retained sequence and returns up to max_count records (saturated at
// MAX_BURST), or one empty reply when nothing qualifies. A read holds the
// input side through the setup states (clamp, window size, slot lookup) and
// the issue of each record, or of the empty reply; records leave at one per
// clock while m_ready is high, through the memory read port and a single
// output register, and the first one shows on m_valid after the setup states,
// the RAM read register and the output register. Back pressure on m_ready
// stalls the burst for as long as it lasts. A reset-ring beat clears the write
// sequence and write slot; the memory needs no clearing since reads only cover
// slots written since then. Opcode 3 is dropped without effect.
// ----------------------------------------------------------------------------
module sequenced_trace_ring_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  stru_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output stru_pkg::out_t m_data
);

    import stru_pkg::*;

    // control
    state_t            state_reg,  state_next;
    logic [SEQ_W-1:0]  wseq_reg,   wseq_next;
    logic [ADDR_W-1:0] wslot_reg,  wslot_next;

    // read setup / burst tracking
    logic [SEQ_W-1:0]  cur_reg,    cur_next;
    logic [CNT_W-1:0]  limit_reg,  limit_next;
    logic [AV_W-1:0]   avail_reg,  avail_next;
    logic              have_reg,   have_next;
    logic              empty_reg,  empty_next;
    logic [CNT_W-1:0]  left_reg,   left_next;
    logic [ADDR_W-1:0] rslot_reg,  rslot_next;

    // memory output stage: tags for the data sitting in the RAM read register
    logic              p_valid_reg, p_valid_next;
    logic              p_kind_reg,  p_kind_next;
    logic [SEQ_W-1:0]  p_seq_reg,   p_seq_next;
    logic              p_last_reg,  p_last_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg,  m_data_next;

    // memory port signals
    logic              wr_en;
    ent_t              wr_ent;
    logic              rd_en;
    ent_t              rd_ent;

    logic [SEQ_W-1:0]  oldest;
    logic              p_move;
    logic              p_free;

    stru_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wslot_reg),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rslot_reg),
        .rd_data (rd_ent)
    );

    assign wr_ent = '{time_ms:    s_data.time_ms,
                      value_bits: s_data.value_bits,
                      name:       clean_name(s_data.name_chars)};

    // oldest sequence still held in the ring
    assign oldest = (wseq_reg > DEPTH_SEQ) ? (wseq_reg - DEPTH_SEQ) : '0;

    // RAM read register drains into the output register when that is free;
    // a new read is issued only when the RAM register is free or draining
    assign p_move = p_valid_reg && (!m_valid_reg || m_ready);
    assign p_free = !p_valid_reg || p_move;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wseq_reg    <= '0;
            wslot_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wseq_reg    <= wseq_next;
            wslot_reg   <= wslot_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        limit_reg  <= limit_next;
        avail_reg  <= avail_next;
        have_reg   <= have_next;
        empty_reg  <= empty_next;
        left_reg   <= left_next;
        rslot_reg  <= rslot_next;
        p_kind_reg <= p_kind_next;
        p_seq_reg  <= p_seq_next;
        p_last_reg <= p_last_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        wseq_next    = wseq_reg;
        wslot_next   = wslot_reg;
        cur_next     = cur_reg;
        limit_next   = limit_reg;
        avail_next   = avail_reg;
        have_next    = have_reg;
        empty_next   = empty_reg;
        left_next    = left_reg;
        rslot_next   = rslot_reg;
        p_valid_next = p_valid_reg;
        p_kind_next  = p_kind_reg;
        p_seq_next   = p_seq_reg;
        p_last_next  = p_last_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        // output side
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (p_move) begin
            p_valid_next             = 1'b0;
            m_valid_next             = 1'b1;
            m_data_next.kind         = p_kind_reg;
            m_data_next.last         = p_last_reg;
            if (p_kind_reg == KIND_EMPTY) begin
                m_data_next.seq          = '0;
                m_data_next.sample_time  = '0;
                m_data_next.sample_value = '0;
                m_data_next.sample_name  = '0;
                m_data_next.next_seq     = p_seq_reg;
            end else begin
                m_data_next.seq          = p_seq_reg;
                m_data_next.sample_time  = rd_ent.time_ms;
                m_data_next.sample_value = rd_ent.value_bits;
                m_data_next.sample_name  = rd_ent.name;
                m_data_next.next_seq     = p_seq_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.opcode)
                        OP_PUT: begin
                            wr_en      = 1'b1;
                            wseq_next  = wseq_reg + 1'b1;
                            wslot_next = (wslot_reg == ADDR_W'(RING_DEPTH - 1)) ?
                                         '0 : wslot_reg + 1'b1;
                        end
                        OP_READ: begin
                            cur_next   = s_data.since_seq;
                            limit_next = (s_data.max_count > MAX_BURST_C) ?
                                         MAX_BURST_C : s_data.max_count;
                            state_next = ST_CLAMP;
                        end
                        OP_RESET: begin
                            wseq_next  = '0;
                            wslot_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLAMP: begin
                if (cur_reg < oldest) begin
                    cur_next = oldest;
                end
                state_next = ST_SIZE;
            end
            ST_SIZE: begin
                // avail is at most the depth whenever have is set
                have_next  = (cur_reg < wseq_reg);
                avail_next = AV_W'(wseq_reg - cur_reg);
                state_next = ST_SLOT;
            end
            ST_SLOT: begin
                empty_next = !have_reg || (limit_reg == '0);
                left_next  = (SEQ_W'(avail_reg) < SEQ_W'(limit_reg)) ?
                             CNT_W'(avail_reg) : limit_reg;
                // slot of cur = write slot stepped back by avail, wrapped
                if (AV_W'(wslot_reg) >= avail_reg) begin
                    rslot_next = ADDR_W'(AV_W'(wslot_reg) - avail_reg);
                end else begin
                    rslot_next = ADDR_W'(AV_W'(wslot_reg) + AV_W'(RING_DEPTH) - avail_reg);
                end
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (p_free) begin
                    p_valid_next = 1'b1;
                    p_seq_next   = cur_reg;
                    if (empty_reg) begin
                        p_kind_next = KIND_EMPTY;
                        p_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        rd_en       = 1'b1;
                        p_kind_next = KIND_SAMPLE;
                        p_last_next = (left_reg == CNT_W'(1));
                        cur_next    = cur_reg + 1'b1;
                        left_next   = left_reg - 1'b1;
                        rslot_next  = (rslot_reg == ADDR_W'(RING_DEPTH - 1)) ?
                                      '0 : rslot_reg + 1'b1;
                        if (left_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/stru_checker.sv
// ----------------------------------------------------------------------------
// stru_checker
// Port-level checks for the trace ring, bound to the top level.
// ----------------------------------------------------------------------------
module stru_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input stru_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input stru_pkg::out_t m_data
);

    import stru_pkg::*;

    // stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // sample record points at the following sequence
    a_next_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.kind == KIND_SAMPLE) |-> m_data.next_seq == m_data.seq + 1'b1)
        else $error("sample next_seq is not seq + 1");

    // burst records follow back to back with consecutive sequences
    a_burst_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
            m_valid && (m_data.seq == $past(m_data.next_seq)))
        else $error("burst gap or sequence skip");

    // input side busy right after a read beat
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_READ) |=> !s_ready)
        else $error("read beat did not hold off input");

endmodule

bind sequenced_trace_ring_unit stru_checker u_stru_checker (.*);
